### rtl/core/orrs_pkg.sv
// Shared types, constants and segment decoding for the outlier-rejecting range sweep.
package orrs_pkg;

    localparam int DIST_W     = 12;
    localparam int MAX_OUT_W  = 6;
    localparam int STEP_W     = 8;
    localparam int ANGLE_W    = 11;
    localparam int STEPPED_W  = 12;
    localparam int SEG_W      = 7;
    localparam int SECTOR_W   = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 64;
    localparam int OUT_BITS   = DIST_W + 3 * SEG_W + ANGLE_W + SECTOR_W + 2 * SEG_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTLIERS      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT       = 4'd3;

    localparam logic [DIST_W-1:0]    RST_OUTLIER_THRESHOLD = 12'd250;
    localparam logic [MAX_OUT_W-1:0] RST_MAX_OUTLIERS      = 6'd6;
    localparam logic [STEP_W-1:0]    RST_ANGLE_STEP        = 8'd10;
    localparam logic [ANGLE_W-1:0]   RST_ANGLE_LIMIT       = 11'd1793;

    // x / 10 = (x * 6554) >> 16, exact for x below 16370
    // x / 150 = (x * 437) >> 16, exact for quotients below 30
    localparam int RECIP10_W  = 13;
    localparam int RECIP150_W = 9;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP10_W-1:0]  RECIP10  = 13'd6554;
    localparam logic [RECIP150_W-1:0] RECIP150 = 9'd437;
    localparam logic [DIST_W-1:0]     DECIMAL  = 12'd10;

    // Digit sequencer steps
    localparam int STEP_IDX_W = 3;
    localparam logic [STEP_IDX_W-1:0] DIG_MEAN_ONES     = 3'd0;
    localparam logic [STEP_IDX_W-1:0] DIG_MEAN_TENS     = 3'd1;
    localparam logic [STEP_IDX_W-1:0] DIG_MEAN_HUNDREDS = 3'd2;
    localparam logic [STEP_IDX_W-1:0] DIG_ANGLE_TENTHS  = 3'd3;
    localparam logic [STEP_IDX_W-1:0] DIG_ANGLE_UNITS   = 3'd4;
    localparam logic [STEP_IDX_W-1:0] DIG_ANGLE_TENS    = 3'd5;

    localparam logic [SEG_W-1:0] SEG_CODE_ZERO = 7'h3F;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_START,
        S_DIV,
        S_DIGIT,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic                  accept;
        logic                  start;
        logic                  digit;
        logic [STEP_IDX_W-1:0] digit_sel;
        logic                  load;
    } t_cmd;

    typedef struct packed {
        logic last_req;
        logic div_done;
        logic out_free;
    } t_status;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/orrs_div.sv
// Restoring divider, one quotient bit per cycle.
module orrs_div #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### rtl/core/orrs_dp.sv
// Datapath: config registers, batch accumulators, angle stepping, digit unit, output register.
module orrs_dp #(
    parameter int SAMPLES_PER_BATCH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  orrs_pkg::t_cmd                      i_cmd,
    output orrs_pkg::t_status                   o_status,
    input  logic                                i_s_tvalid,
    input  logic [orrs_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_cfg_valid,
    input  logic [orrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [orrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [orrs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int DIST_W    = orrs_pkg::DIST_W;
    localparam int ANGLE_W   = orrs_pkg::ANGLE_W;
    localparam int SEG_W     = orrs_pkg::SEG_W;
    localparam int BATCH_W   = $clog2(SAMPLES_PER_BATCH);
    localparam int CNT_W     = $clog2(SAMPLES_PER_BATCH + 1);
    localparam int SUM_W     = DIST_W + $clog2(SAMPLES_PER_BATCH);
    localparam int CMP_W     = (CNT_W > orrs_pkg::MAX_OUT_W) ? CNT_W : orrs_pkg::MAX_OUT_W;
    localparam int DPROD_W   = DIST_W + orrs_pkg::RECIP10_W;
    localparam int SPROD_W   = ANGLE_W + orrs_pkg::RECIP150_W;
    localparam int Q_W       = DPROD_W - orrs_pkg::RECIP_SHIFT;
    localparam logic [BATCH_W-1:0] BATCH_LAST = BATCH_W'(SAMPLES_PER_BATCH - 1);

    // configuration
    logic [DIST_W-1:0]              r_thr;
    logic [orrs_pkg::MAX_OUT_W-1:0] r_max_out;
    logic [orrs_pkg::STEP_W-1:0]    r_step;
    logic [ANGLE_W-1:0]             r_limit;

    // batch state
    logic [BATCH_W-1:0] r_batch;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_vcnt;
    logic [CNT_W-1:0]   r_outl;
    logic [ANGLE_W-1:0] r_scan;

    // per-result working registers
    logic                              r_reject;
    logic [ANGLE_W-1:0]                r_servo;
    logic [orrs_pkg::STEPPED_W-1:0]    r_stepped;
    logic                              r_end;
    logic [DIST_W-1:0]                 r_dig_val;
    logic [orrs_pkg::SECTOR_W-1:0]     r_sector;
    logic [SEG_W-1:0]                  r_seg_m1, r_seg_m10, r_seg_m100, r_seg_a1, r_seg_a10;

    // output register
    logic                              r_out_valid;
    logic                              r_out_last;
    logic [orrs_pkg::M_TDATA_W-1:0]    r_out_data;

    logic [DIST_W-1:0]              sample;
    logic                           req;
    logic                           is_outlier;
    logic                           reject;
    logic [orrs_pkg::STEPPED_W-1:0] n_stepped;
    logic                           n_end;
    logic [SUM_W-1:0]               quotient;
    logic                           div_done;
    logic [DIST_W-1:0]              mean;
    logic [DIST_W-1:0]              dig_x;
    logic [DPROD_W-1:0]             dig_prod;
    logic [Q_W-1:0]                 dig_q;
    logic [DIST_W-1:0]              dig_rem;
    logic [SEG_W-1:0]               dig_seg;
    logic [SPROD_W-1:0]             sec_prod;

    assign sample     = i_s_tdata[DIST_W-1:0];
    assign req        = i_cmd.accept && i_s_tvalid;
    assign is_outlier = sample > r_thr;
    assign reject     = (CMP_W'(r_outl) > CMP_W'(r_max_out)) || (r_vcnt == '0);
    assign n_stepped  = orrs_pkg::STEPPED_W'(r_scan) + orrs_pkg::STEPPED_W'(r_step);
    assign n_end      = n_stepped > orrs_pkg::STEPPED_W'(r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= orrs_pkg::RST_OUTLIER_THRESHOLD;
            r_max_out <= orrs_pkg::RST_MAX_OUTLIERS;
            r_step    <= orrs_pkg::RST_ANGLE_STEP;
            r_limit   <= orrs_pkg::RST_ANGLE_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                orrs_pkg::REG_OUTLIER_THRESHOLD: r_thr     <= i_cfg_data[DIST_W-1:0];
                orrs_pkg::REG_MAX_OUTLIERS:      r_max_out <= i_cfg_data[orrs_pkg::MAX_OUT_W-1:0];
                orrs_pkg::REG_ANGLE_STEP:        r_step    <= i_cfg_data[orrs_pkg::STEP_W-1:0];
                orrs_pkg::REG_ANGLE_LIMIT:       r_limit   <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= '0;
            r_sum   <= '0;
            r_vcnt  <= '0;
            r_outl  <= '0;
            r_scan  <= '0;
        end else if (i_cmd.start) begin
            // totals already handed to the divider on this edge
            r_sum  <= '0;
            r_vcnt <= '0;
            r_outl <= '0;
            r_scan <= n_end ? '0 : n_stepped[ANGLE_W-1:0];
        end else if (req) begin
            r_batch <= (r_batch == BATCH_LAST) ? '0 : r_batch + 1'b1;
            if (is_outlier) begin
                r_outl <= r_outl + 1'b1;
            end else begin
                r_sum  <= r_sum + SUM_W'(sample);
                r_vcnt <= r_vcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_reject  <= reject;
            r_servo   <= r_scan;
            r_stepped <= n_stepped;
            r_end     <= n_end;
        end
    end

    orrs_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (r_sum),
        .i_divisor  (r_vcnt),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign mean = r_reject ? '0 : quotient[DIST_W-1:0];

    // one decimal digit per step: q = x / 10 by reciprocal, digit = x - 10q
    always_comb begin
        case (i_cmd.digit_sel)
            orrs_pkg::DIG_MEAN_ONES:    dig_x = mean;
            orrs_pkg::DIG_ANGLE_TENTHS: dig_x = r_stepped;
            default:                    dig_x = r_dig_val;
        endcase
    end

    assign dig_prod = DPROD_W'(dig_x) * DPROD_W'(orrs_pkg::RECIP10);
    assign dig_q    = dig_prod[DPROD_W-1:orrs_pkg::RECIP_SHIFT];
    assign dig_rem  = dig_x - DIST_W'(dig_q) * orrs_pkg::DECIMAL;
    assign dig_seg  = orrs_pkg::seg_of(dig_rem[3:0]);
    assign sec_prod = SPROD_W'(r_servo) * SPROD_W'(orrs_pkg::RECIP150);

    always_ff @(posedge i_clk) begin
        if (i_cmd.digit) begin
            r_dig_val <= DIST_W'(dig_q);
            case (i_cmd.digit_sel)
                orrs_pkg::DIG_MEAN_ONES: begin
                    r_seg_m1 <= dig_seg;
                    r_sector <= sec_prod[orrs_pkg::RECIP_SHIFT +: orrs_pkg::SECTOR_W];
                end
                orrs_pkg::DIG_MEAN_TENS:     r_seg_m10  <= dig_seg;
                orrs_pkg::DIG_MEAN_HUNDREDS: r_seg_m100 <= dig_seg;
                orrs_pkg::DIG_ANGLE_UNITS:   r_seg_a1   <= dig_seg;
                orrs_pkg::DIG_ANGLE_TENS:    r_seg_a10  <= dig_seg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last <= r_end;
            r_out_data <= {{(orrs_pkg::M_TDATA_W - orrs_pkg::OUT_BITS){1'b0}},
                           r_seg_a10, r_seg_a1, r_sector, r_servo,
                           r_seg_m100, r_seg_m10, r_seg_m1, mean};
        end
    end

    assign o_status.last_req = i_s_tvalid && (r_batch == BATCH_LAST);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/core/orrs_ctrl.sv
// Controller: sequences accumulate, divide, digit extraction and result load.
module orrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  orrs_pkg::t_status i_status,
    output orrs_pkg::t_cmd    o_cmd
);

    orrs_pkg::t_state                  r_state, n_state;
    logic [orrs_pkg::STEP_IDX_W-1:0]   r_dsel, n_dsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= orrs_pkg::S_ACCUM;
            r_dsel  <= orrs_pkg::DIG_MEAN_ONES;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_dsel          = r_dsel;
        o_cmd           = '0;
        o_cmd.digit_sel = r_dsel;
        case (r_state)
            orrs_pkg::S_ACCUM: begin
                o_cmd.accept = 1'b1;
                if (i_status.last_req) begin
                    n_state = orrs_pkg::S_START;
                end
            end
            orrs_pkg::S_START: begin
                o_cmd.start = 1'b1;
                n_state     = orrs_pkg::S_DIV;
            end
            orrs_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = orrs_pkg::S_DIGIT;
                    n_dsel  = orrs_pkg::DIG_MEAN_ONES;
                end
            end
            orrs_pkg::S_DIGIT: begin
                o_cmd.digit = 1'b1;
                if (r_dsel == orrs_pkg::DIG_ANGLE_TENS) begin
                    n_state = orrs_pkg::S_LOAD;
                end else begin
                    n_dsel = r_dsel + 1'b1;
                end
            end
            orrs_pkg::S_LOAD: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = orrs_pkg::S_ACCUM;
                end
            end
            default: n_state = orrs_pkg::S_ACCUM;
        endcase
    end

endmodule

### rtl/core/outlier_rejecting_range_sweep.sv
// Top level of the outlier-rejecting range sweep: controller plus datapath.
//
//  Channel  Dir  Handshake                      Payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  sample_distance
//  m_axis   out  m_axis_tvalid / m_axis_tready  batch result, tlast = sweep_end
//  cfg      in   i_cfg_valid / o_cfg_ready      register index, write data
//
//  Samples other than the last of a batch are taken back to back.
//  The last sample holds off the input while the bit-serial divider works through
//  SUM_W quotient bits, SUM_W being 12 + clog2(SAMPLES_PER_BATCH) (17 at 32), and
//  while the six-step digit unit runs; longer if the previous result is not yet taken.
//  The result sits in an output register, so sampling resumes while it waits.
//  Reset is synchronous, active low; config writes are taken every cycle.
module outlier_rejecting_range_sweep #(
    parameter int SAMPLES_PER_BATCH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [orrs_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [11:0] sample_distance
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] mean_distance, [18:12] mean_ones_segments, [25:19] mean_tens_segments,
    // [32:26] mean_hundreds_segments, [43:33] servo_angle, [47:44] led_sector,
    // [54:48] angle_units_segments, [61:55] angle_tens_segments
    output logic [orrs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,   // sweep_end
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [orrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [orrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    orrs_pkg::t_cmd    cmd;
    orrs_pkg::t_status status;

    orrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    orrs_dp #(
        .SAMPLES_PER_BATCH (SAMPLES_PER_BATCH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

    assign s_axis_tready = cmd.accept;
    assign o_cfg_ready   = 1'b1;

endmodule

### rtl/core/orrs_checker.sv
// Port-level checks for the outlier-rejecting range sweep, bound to the top level.
module orrs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [orrs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic        r_after_end;
    logic [11:0] servo;
    logic [11:0] sector_lo;

    assign servo     = {1'b0, m_axis_tdata[43:33]};
    assign sector_lo = 12'(m_axis_tdata[47:44]) * 12'd150;

    // set when a result with sweep_end is taken, cleared when a result without it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_after_end <= m_axis_tlast;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_zero_mean_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[11:0] == 12'd0) |->
            (m_axis_tdata[18:12] == orrs_pkg::SEG_CODE_ZERO) &&
            (m_axis_tdata[25:19] == orrs_pkg::SEG_CODE_ZERO) &&
            (m_axis_tdata[32:26] == orrs_pkg::SEG_CODE_ZERO))
        else $error("zero mean without zero digits");

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (servo >= sector_lo) && (servo < sector_lo + 12'd150))
        else $error("LED sector does not match servo angle");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_after_end |-> (servo == 12'd0))
        else $error("sweep did not restart at zero");

endmodule

bind outlier_rejecting_range_sweep orrs_checker u_orrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
